// ----- hdl/tcst_pkg.sv -----
package tcst_pkg;
	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int ORD_W = $clog2(SLOT_COUNT + 1);

	localparam logic [2:0] CMD_DOWN = 3'd0;
	localparam logic [2:0] CMD_MOVE = 3'd1;
	localparam logic [2:0] CMD_UP = 3'd2;
	localparam logic [2:0] CMD_RELEASE = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;

	localparam logic [1:0] PH_INACTIVE = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_MOVE = 2'd2;
	localparam logic [1:0] PH_UP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [30:0] pointer_id;
		logic signed [31:0] source;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [3:0] order_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [30:0] out_pointer_id;
		logic signed [31:0] out_source;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [1:0] out_phase;
		logic [3:0] active_count;
		logic oldest_active;
	} rsp_t;

	typedef struct packed {
		logic [30:0] id;
		logic [31:0] source;
		logic [31:0] x;
		logic [31:0] y;
		logic [1:0] phase;
	} entry_t;
endpackage

// ----- hdl/tcst_if.sv -----
interface tcst_cmd_if;
	import tcst_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcst_rsp_if;
	import tcst_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/touch_contact_slot_table.sv -----
// Contact slot table. Slot payloads (id, source, x, y, phase) live in a
// synchronous memory with a registered read port; valid bits and arrival orders
// sit in flip-flops. Each command walks the slots one memory read per cycle;
// release also frees all up contacts during that walk. The next command is
// taken once the result has been accepted on the response channel.
module touch_contact_slot_table (
	input logic clk,
	input logic arst_n,
	tcst_cmd_if.sink cmd,
	tcst_rsp_if.source rsp
);
	import tcst_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_OUT = 3'd3;

	entry_t mem [SLOT_COUNT];
	entry_t rd_q;
	logic mem_we;
	logic [SLOT_W-1:0] wr_addr;
	entry_t wr_data;
	logic [SLOT_W-1:0] rd_addr;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [ORD_W-1:0] order_q [SLOT_COUNT];
	logic [ORD_W-1:0] live_q;
	logic oldest_q;
	logic [SLOT_W:0] idx_q;
	logic rd_vld_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	rsp_t rsp_q;
	logic [1:0] status_q;
	entry_t res_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	logic rd_match;
	logic [SLOT_COUNT-1:0] free_v;
	logic [SLOT_W-1:0] free_idx;
	logic free_any;

	always_comb begin
		free_v = ~valid_q;
		free_idx = '0;
		free_any = 1'b0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--)
			if (free_v[k]) begin
				free_idx = SLOT_W'(k);
				free_any = 1'b1;
			end
		rd_addr = idx_q[SLOT_W-1:0];
		rd_match = 1'b0;
		if (rd_vld_q && valid_q[rd_idx_q]) begin
			if (cmd_q.command == CMD_QUERY)
				rd_match = ({1'b0, order_q[rd_idx_q]} == (ORD_W+1)'(cmd_q.order_index))
					|| (ORD_W < 4 && 4'(order_q[rd_idx_q]) == cmd_q.order_index);
			else if (cmd_q.command == CMD_RELEASE)
				rd_match = rd_q.phase == PH_UP;
			else
				rd_match = rd_q.id == cmd_q.pointer_id;
		end
		mem_we = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = '{id: cmd_q.pointer_id, source: cmd_q.source, x: cmd_q.x_bits,
			y: cmd_q.y_bits, phase: PH_DOWN};
		if (state_q == S_WRITE) begin
			unique case (cmd_q.command)
				CMD_DOWN: begin
					mem_we = !hit_q && free_any;
					wr_addr = free_idx;
				end
				CMD_MOVE, CMD_UP: begin
					mem_we = hit_q;
					wr_data.id = res_q.id;
					wr_data.phase = (cmd_q.command == CMD_MOVE) ? PH_MOVE : PH_UP;
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			valid_q <= '0;
			live_q <= '0;
			oldest_q <= 1'b0;
			idx_q <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			res_q <= '0;
			status_q <= ST_OK;
			for (int k = 0; k < SLOT_COUNT; k++)
				order_q[k] <= ORD_W'(SLOT_COUNT);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q <= cmd.data;
						idx_q <= '0;
						rd_vld_q <= 1'b0;
						hit_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_q <= idx_q < (SLOT_W+1)'(SLOT_COUNT);
					rd_idx_q <= idx_q[SLOT_W-1:0];
					if (idx_q < (SLOT_W+1)'(SLOT_COUNT))
						idx_q <= idx_q + 1'b1;
					if (rd_match) begin
						if (cmd_q.command == CMD_RELEASE) begin
							if (order_q[rd_idx_q] == '0)
								oldest_q <= 1'b0;
							valid_q[rd_idx_q] <= 1'b0;
							order_q[rd_idx_q] <= ORD_W'(SLOT_COUNT);
							if (live_q != '0)
								live_q <= live_q - 1'b1;
							for (int j = 0; j < SLOT_COUNT; j++)
								if (valid_q[j] && order_q[j] > order_q[rd_idx_q])
									order_q[j] <= order_q[j] - 1'b1;
						end else if (!hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rd_idx_q;
							res_q <= rd_q;
						end
					end
					if (!rd_vld_q && idx_q == (SLOT_W+1)'(SLOT_COUNT))
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					unique case (cmd_q.command)
						CMD_DOWN: begin
							if (hit_q)
								status_q <= ST_DUP;
							else if (!free_any)
								status_q <= ST_FULL;
							else begin
								status_q <= ST_OK;
								valid_q[free_idx] <= 1'b1;
								order_q[free_idx] <= live_q;
								if (live_q == '0)
									oldest_q <= 1'b1;
								live_q <= live_q + 1'b1;
							end
						end
						CMD_MOVE, CMD_UP: status_q <= hit_q ? ST_OK : ST_MISSING;
						default: status_q <= ST_OK;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic qhit;
	assign qhit = hit_q && cmd_q.command == CMD_QUERY;
	always_comb begin
		rsp_q.status = status_q;
		rsp_q.found = qhit;
		rsp_q.out_pointer_id = qhit ? res_q.id : '0;
		rsp_q.out_source = qhit ? res_q.source : '0;
		rsp_q.out_x = qhit ? res_q.x : '0;
		rsp_q.out_y = qhit ? res_q.y : '0;
		rsp_q.out_phase = qhit ? res_q.phase : PH_INACTIVE;
		rsp_q.active_count = 4'(live_q);
		rsp_q.oldest_active = oldest_q;
	end

	assign cmd.ready = state_q == S_IDLE;
	assign rsp.valid = state_q == S_OUT;
	assign rsp.data = rsp_q;
endmodule

// ----- verif/tb_touch_contact_slot_table.sv -----
module tb_touch_contact_slot_table;
	import tcst_pkg::*;

	class contact_scoreboard;
		logic slot_live [SLOT_COUNT];
		entry_t slot_entry [SLOT_COUNT];
		int slot_rank [SLOT_COUNT];
		int live_total;
		bit oldest_held;
		rsp_t pending_rsp [$];
		int mismatches;

		function new();
			for (int k = 0; k < SLOT_COUNT; k++) begin
				slot_live[k] = 0;
				slot_entry[k] = '0;
				slot_rank[k] = SLOT_COUNT;
			end
			live_total = 0;
			oldest_held = 0;
			mismatches = 0;
		endfunction

		function int find_contact(logic [30:0] id);
			for (int k = 0; k < SLOT_COUNT; k++)
				if (slot_live[k] && slot_entry[k].id == id) return k;
			return -1;
		endfunction

		function void note_command(cmd_t c);
			rsp_t r;
			int k;
			int gone;
			r = '0;
			r.status = ST_OK;
			case (c.command)
				CMD_DOWN: begin
					if (find_contact(c.pointer_id) >= 0) r.status = ST_DUP;
					else begin
						k = -1;
						for (int j = 0; j < SLOT_COUNT; j++)
							if (!slot_live[j] && k < 0) k = j;
						if (k < 0) r.status = ST_FULL;
						else begin
							slot_live[k] = 1;
							slot_entry[k] = {c.pointer_id, c.source, c.x_bits,
								c.y_bits, PH_DOWN};
							slot_rank[k] = live_total;
							if (live_total == 0) oldest_held = 1;
							live_total++;
						end
					end
				end
				CMD_MOVE, CMD_UP: begin
					k = find_contact(c.pointer_id);
					if (k < 0) r.status = ST_MISSING;
					else slot_entry[k] = {c.pointer_id, c.source, c.x_bits, c.y_bits,
						(c.command == CMD_MOVE) ? PH_MOVE : PH_UP};
				end
				CMD_RELEASE: begin
					for (int j = 0; j < SLOT_COUNT; j++) begin
						if (slot_live[j] && slot_entry[j].phase == PH_UP) begin
							gone = slot_rank[j];
							if (gone == 0) oldest_held = 0;
							slot_live[j] = 0;
							slot_entry[j] = '0;
							slot_rank[j] = SLOT_COUNT;
							if (live_total > 0) live_total--;
							for (int m = 0; m < SLOT_COUNT; m++)
								if (slot_live[m] && slot_rank[m] > gone) slot_rank[m]--;
						end
					end
				end
				CMD_QUERY: begin
					for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
						if (slot_live[j] && slot_rank[j] == int'(c.order_index)) begin
							r.found = 1;
							r.out_pointer_id = slot_entry[j].id;
							r.out_source = slot_entry[j].source;
							r.out_x = slot_entry[j].x;
							r.out_y = slot_entry[j].y;
							r.out_phase = slot_entry[j].phase;
						end
					end
				end
				default: ;
			endcase
			r.active_count = live_total[3:0];
			r.oldest_active = oldest_held;
			pending_rsp.push_back(r);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", got);
				return;
			end
			want = pending_rsp.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tcst_cmd_if cmd_ch();
	tcst_rsp_if rsp_ch();
	contact_scoreboard board;
	int send_idle_pct;
	int recv_stall_pct;
	logic [30:0] id_pool [6];

	touch_contact_slot_table dut (.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink),
		.rsp(rsp_ch.source));

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
		if (arst_n && cmd_ch.valid && cmd_ch.ready) board.note_command(cmd_ch.data);
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_command(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	function automatic cmd_t random_field_cmd(logic [2:0] op);
		cmd_t c;
		c.command = op;
		c.pointer_id = ($urandom_range(3) == 0) ? 31'($urandom()) : id_pool[$urandom_range(5)];
		c.source = $urandom();
		c.x_bits = $urandom();
		c.y_bits = $urandom();
		c.order_index = 4'($urandom_range(15));
		return c;
	endfunction

	task automatic random_command();
		int pick;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < 28) op = CMD_DOWN;
		else if (pick < 48) op = CMD_MOVE;
		else if (pick < 64) op = CMD_UP;
		else if (pick < 74) op = CMD_RELEASE;
		else if (pick < 96) op = CMD_QUERY;
		else op = 3'($urandom_range(7, 5));
		send_command(random_field_cmd(op));
	endtask

	initial begin
		cmd_t c;
		board = new();
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		id_pool = '{31'h0, 31'h7fffffff, 31'h1, 31'h2aaaaaaa, 31'h55555555, 31'h3};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 9; i++) begin
			c = '0;
			c.command = CMD_DOWN;
			c.pointer_id = (i == 8) ? 31'h12345 : ((i == 0) ? 31'h7fffffff : 31'(i));
			c.source = (i[0]) ? 32'h80000000 : 32'h7fffffff;
			c.x_bits = (i[0]) ? 32'hffffffff : 32'h0;
			c.y_bits = (i[0]) ? 32'h0 : 32'hffffffff;
			send_command(c);
		end
		c.command = CMD_DOWN;
		c.pointer_id = 31'h1;
		send_command(c);
		c.command = CMD_MOVE;
		send_command(c);
		c.command = CMD_UP;
		c.pointer_id = 31'h7fffffff;
		send_command(c);
		c.pointer_id = 31'h2;
		send_command(c);
		c.pointer_id = 31'h999;
		send_command(c);
		c.command = CMD_MOVE;
		send_command(c);
		for (int o = 0; o < 16; o += 5) begin
			c.command = CMD_QUERY;
			c.order_index = 4'(o);
			send_command(c);
		end
		c.command = CMD_RELEASE;
		send_command(c);
		c.command = CMD_QUERY;
		c.order_index = 4'd0;
		send_command(c);
		c.command = 3'd7;
		send_command(c);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 31) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 31) : 0;
			for (int i = 0; i < 285; i++) random_command();
		end
		cmd_ch.valid <= 1'b0;
		send_idle_pct = 0;

		while (board.pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
hdl/tcst_pkg.sv
hdl/tcst_if.sv
hdl/touch_contact_slot_table.sv
verif/tb_touch_contact_slot_table.sv
